[src/ota_pkg.sv]
package ota_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int TEMP_W     = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  localparam int TEMP_CEIL      = 12500;
  localparam int TEMP_FLOOR_MAG = 32768;

  typedef logic [SAMPLE_W-1:0]   sample_t;
  typedef logic signed [TEMP_W-1:0] temp_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam cfg_idx_t REG_NUM_READINGS  = 3'd0;
  localparam cfg_idx_t REG_REF_VOLTAGE   = 3'd1;
  localparam cfg_idx_t REG_AVG_DEPTH     = 3'd2;
  localparam cfg_idx_t REG_ZERO_OFFSET   = 3'd3;
  localparam cfg_idx_t REG_SLOPE_DIVISOR = 3'd4;

  localparam logic [2:0]  RST_NUM_READINGS  = 3'd1;
  localparam logic [15:0] RST_REF_VOLTAGE   = 16'd3300;
  localparam logic [3:0]  RST_AVG_DEPTH     = 4'd1;
  localparam logic [15:0] RST_ZERO_OFFSET   = 16'd500;
  localparam logic [15:0] RST_SLOPE_DIVISOR = 16'd10;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[src/ota_fifo.sv]
module ota_fifo #(
  parameter int W = 22
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [W-1:0]     push_data,
  input  logic             pop,
  output logic [W-1:0]     pop_data,
  output ota_pkg::q_stat_t stat
);
  import ota_pkg::*;

  logic [W-1:0] mem [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  assign stat.full  = (count == 2'd2);
  assign stat.empty = (count == 2'd0);
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule

[src/ota_front.sv]
module ota_front #(
  parameter int NW    = 3,
  parameter int SUM_W = 19
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  ota_pkg::sample_t    s_tdata,
  input  logic [NW-1:0]       eff_n,
  input  ota_pkg::q_stat_t    q_stat,
  output logic                push,
  output logic [NW+SUM_W-1:0] push_data
);
  import ota_pkg::*;

  logic [SUM_W-1:0] sample_sum;
  logic [NW-1:0]    samples_taken;
  logic [SUM_W-1:0] sum_next;
  logic [NW-1:0]    taken_next;
  logic             accept;
  logic             group_done;

  assign s_tready   = !q_stat.full;
  assign accept     = s_tvalid && s_tready;
  assign sum_next   = sample_sum + SUM_W'(s_tdata);
  assign taken_next = samples_taken + NW'(1);
  // a lowered count closes the group on the next beat
  assign group_done = (taken_next >= eff_n);
  assign push       = accept && group_done;
  assign push_data  = {eff_n, sum_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum    <= '0;
      samples_taken <= '0;
    end else if (accept) begin
      if (group_done) begin
        sample_sum    <= '0;
        samples_taken <= '0;
      end else begin
        sample_sum    <= sum_next;
        samples_taken <= taken_next;
      end
    end
  end

endmodule

[src/ota_div.sv]
module ota_div #(
  parameter int DW = 35,
  parameter int VW = 19
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);
  import ota_pkg::*;

  localparam int CW = $clog2(DW);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] q;
  logic [VW-1:0] rem;
  logic [VW-1:0] dsr;
  logic [VW:0]   shifted;
  logic [VW:0]   trial;
  logic          fits;

  // restoring division, one quotient bit per cycle
  assign shifted  = {rem, q[DW-1]};
  assign trial    = shifted - {1'b0, dsr};
  assign fits     = !trial[VW];
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && (cnt == CW'(DW - 1));
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(DW - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= '0;
      q   <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      cnt <= cnt + CW'(1);
      rem <= fits ? trial[VW-1:0] : shifted[VW-1:0];
      q   <= {q[DW-2:0], fits};
    end
  end

endmodule

[src/ota_back.sv]
module ota_back #(
  parameter int HD    = 10,
  parameter int NW    = 3,
  parameter int SUM_W = 19,
  parameter int DPW   = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  ota_pkg::q_stat_t    q_stat,
  input  logic [NW+SUM_W-1:0] q_data,
  output logic                pop,
  input  logic [15:0]         ref_voltage,
  input  logic [15:0]         zero_offset,
  input  logic [15:0]         slope,
  input  logic [DPW-1:0]      eff_depth,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [31:0]         m_tdata
);
  import ota_pkg::*;

  localparam int DW = SUM_W + 16;
  localparam int SW = $clog2(HD);
  localparam int AW = TEMP_W + $clog2(HD);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL    = 4'd1;
  localparam logic [3:0] S_MVGO   = 4'd2;
  localparam logic [3:0] S_MVWAIT = 4'd3;
  localparam logic [3:0] S_TGO    = 4'd4;
  localparam logic [3:0] S_TWAIT  = 4'd5;
  localparam logic [3:0] S_CLAMP  = 4'd6;
  localparam logic [3:0] S_WALK   = 4'd7;
  localparam logic [3:0] S_AGO    = 4'd8;
  localparam logic [3:0] S_AWAIT  = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  logic [3:0]              state;
  logic [SUM_W-1:0]        sum_r;
  logic [NW-1:0]           n_r;
  logic [DW-1:0]           prod;
  logic [DW-1:0]           div_a;
  logic [SUM_W-1:0]        div_b;
  logic                    div_go;
  logic                    div_done;
  logic [DW-1:0]           dq;
  logic signed [SUM_W:0]   diff;
  logic                    neg_r;
  temp_t                   temp_r;
  temp_t                   avg_r;
  temp_t                   history [HD];
  logic [SW-1:0]           write_slot;
  logic [SW-1:0]           walk_idx;
  logic [DPW-1:0]          walk_cnt;
  logic signed [AW-1:0]    acc;

  logic [SUM_W-1:0]        mv;
  logic signed [SUM_W:0]   diff_c;
  logic [SUM_W:0]          diff_neg;
  logic [SUM_W-1:0]        diff_mag;
  logic [SUM_W-1:0]        mv_div;
  logic [SUM_W-1:0]        tq;
  temp_t                   temp_c;
  logic [AW-1:0]           acc_neg;
  logic [AW-1:0]           acc_mag;
  logic [TEMP_W-1:0]       aq;
  logic [TEMP_W-1:0]       avg_c;
  logic                    out_free;

  ota_div #(.DW(DW), .VW(SUM_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (dq)
  );

  assign pop = (state == S_IDLE) && !q_stat.empty;

  // sum*ref/65535/n folds into one division by 65535*n
  assign mv_div   = {n_r, 16'h0000} - SUM_W'(n_r);
  assign mv       = dq[SUM_W-1:0];
  assign diff_c   = $signed({1'b0, mv}) - $signed({{(SUM_W - 15){1'b0}}, zero_offset});
  assign diff_neg = -diff;
  assign diff_mag = diff[SUM_W] ? diff_neg[SUM_W-1:0] : diff[SUM_W-1:0];

  assign tq = dq[SUM_W-1:0];
  always_comb begin
    if (!neg_r) begin
      temp_c = (tq > SUM_W'(TEMP_CEIL)) ? TEMP_W'(TEMP_CEIL) : tq[TEMP_W-1:0];
    end else begin
      temp_c = (tq >= SUM_W'(TEMP_FLOOR_MAG)) ? {1'b1, {(TEMP_W - 1){1'b0}}}
                                              : -tq[TEMP_W-1:0];
    end
  end

  assign acc_neg = -acc;
  assign acc_mag = acc[AW-1] ? acc_neg : acc;
  assign aq      = dq[TEMP_W-1:0];
  assign avg_c   = neg_r ? -aq : aq;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      div_go     <= 1'b0;
      write_slot <= '0;
      m_tvalid   <= 1'b0;
      for (int i = 0; i < HD; i++) history[i] <= '0;
    end else begin
      div_go <= (state == S_MVGO) || (state == S_TGO) || (state == S_AGO);
      if (state == S_OUT && out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (!q_stat.empty) state <= S_MUL;
        end
        S_MUL: state <= S_MVGO;
        S_MVGO: begin
          state <= S_MVWAIT;
        end
        S_MVWAIT: begin
          if (div_done) state <= S_TGO;
        end
        S_TGO: begin
          state <= S_TWAIT;
        end
        S_TWAIT: begin
          if (div_done) state <= S_CLAMP;
        end
        S_CLAMP: begin
          history[write_slot] <= temp_c;
          write_slot <= (write_slot == SW'(HD - 1)) ? '0 : write_slot + SW'(1);
          state <= S_WALK;
        end
        S_WALK: begin
          if (walk_cnt + DPW'(1) == eff_depth) state <= S_AGO;
        end
        S_AGO: begin
          state <= S_AWAIT;
        end
        S_AWAIT: begin
          if (div_done) state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        sum_r <= q_data[SUM_W-1:0];
        n_r   <= q_data[NW+SUM_W-1:SUM_W];
      end
      S_MUL: prod <= DW'(sum_r) * DW'(ref_voltage);
      S_MVGO: begin
        div_a <= prod;
        div_b <= mv_div;
      end
      S_MVWAIT: begin
        if (div_done) diff <= diff_c;
      end
      S_TGO: begin
        neg_r <= diff[SUM_W];
        div_a <= DW'(diff_mag);
        div_b <= SUM_W'(slope);
      end
      S_CLAMP: begin
        temp_r   <= temp_c;
        walk_idx <= write_slot;
        walk_cnt <= '0;
        acc      <= '0;
      end
      S_WALK: begin
        acc      <= acc + AW'(history[walk_idx]);
        walk_idx <= (walk_idx == '0) ? SW'(HD - 1) : walk_idx - SW'(1);
        walk_cnt <= walk_cnt + DPW'(1);
      end
      S_AGO: begin
        neg_r <= acc[AW-1];
        div_a <= DW'(acc_mag);
        div_b <= SUM_W'(eff_depth);
      end
      S_AWAIT: begin
        if (div_done) avg_r <= avg_c;
      end
      S_OUT: begin
        if (out_free) m_tdata <= {avg_r, temp_r};
      end
      default: ;
    endcase
  end

endmodule

[src/oversampled_temperature_averager.sv]
// channel   dir  beat fields (lsb first)                  handshake
// s_*       in   tdata[15:0] raw_sample                    tvalid/tready
// m_*       out  tdata[15:0] temperature, [31:16] average  tvalid/tready
// cfg_*     in   cfg_index selects register, cfg_data      cfg_we, no wait
//
// Samples are taken one per cycle while the two-entry conversion queue has room.
// A conversion runs three passes of the bit-serial divider, a walk over the last
// avg_depth history entries, and the control states between pop and result valid.
// Reset clears sums, history ring and pointers.
// A stalled result holds the back end in its last state; the front keeps
// taking samples until the queue fills.
module oversampled_temperature_averager #(
  parameter int HISTORY_DEPTH = 10,
  parameter int MAX_READINGS  = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  ota_pkg::sample_t  s_tdata,   // [15:0] raw_sample
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [31:0]       m_tdata,   // [15:0] temperature, [31:16] average
  input  logic              cfg_we,
  input  ota_pkg::cfg_idx_t cfg_index,
  input  ota_pkg::cfg_data_t cfg_data
);
  import ota_pkg::*;

  localparam int NW    = $clog2(MAX_READINGS + 1);
  localparam int SUM_W = SAMPLE_W + NW;
  localparam int DPW   = $clog2(HISTORY_DEPTH + 1);

  logic [2:0]  num_readings;
  logic [15:0] ref_voltage;
  logic [3:0]  avg_depth;
  logic [15:0] zero_offset;
  logic [15:0] slope_divisor;

  logic [NW-1:0]       eff_n;
  logic [DPW-1:0]      eff_depth;
  logic [15:0]         eff_slope;
  q_stat_t             q_stat;
  logic                push;
  logic                pop;
  logic [NW+SUM_W-1:0] push_data;
  logic [NW+SUM_W-1:0] pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_readings  <= RST_NUM_READINGS;
      ref_voltage   <= RST_REF_VOLTAGE;
      avg_depth     <= RST_AVG_DEPTH;
      zero_offset   <= RST_ZERO_OFFSET;
      slope_divisor <= RST_SLOPE_DIVISOR;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUM_READINGS:  num_readings  <= cfg_data[2:0];
        REG_REF_VOLTAGE:   ref_voltage   <= cfg_data;
        REG_AVG_DEPTH:     avg_depth     <= cfg_data[3:0];
        REG_ZERO_OFFSET:   zero_offset   <= cfg_data;
        REG_SLOPE_DIVISOR: slope_divisor <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (num_readings == '0) eff_n = NW'(1);
    else if (int'(num_readings) > MAX_READINGS) eff_n = NW'(MAX_READINGS);
    else eff_n = NW'(num_readings);

    if (avg_depth == '0) eff_depth = DPW'(1);
    else if (int'(avg_depth) > HISTORY_DEPTH) eff_depth = DPW'(HISTORY_DEPTH);
    else eff_depth = DPW'(avg_depth);
  end

  assign eff_slope = (slope_divisor == '0) ? 16'd1 : slope_divisor;

  ota_front #(.NW(NW), .SUM_W(SUM_W)) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .eff_n     (eff_n),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  ota_fifo #(.W(NW + SUM_W)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  ota_back #(.HD(HISTORY_DEPTH), .NW(NW), .SUM_W(SUM_W), .DPW(DPW)) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_stat      (q_stat),
    .q_data      (pop_data),
    .pop         (pop),
    .ref_voltage (ref_voltage),
    .zero_offset (zero_offset),
    .slope       (eff_slope),
    .eff_depth   (eff_depth),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

endmodule

[src/ota_checker.sv]
module ota_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);
  import ota_pkg::*;

  // a waiting result beat must not change
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  a_rst_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_temp_ceil: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[15:0]) <= $signed(TEMP_W'(TEMP_CEIL))))
    else $error("temperature above ceiling");

  a_avg_ceil: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[31:16]) <= $signed(TEMP_W'(TEMP_CEIL))))
    else $error("average above ceiling");

endmodule

bind oversampled_temperature_averager ota_checker u_ota_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

[bench/oversampled_temperature_averager_tb.sv]
`timescale 1ns / 100ps

module oversampled_temperature_averager_tb;
  import ota_pkg::*;

  localparam int RING_DEPTH    = 10;
  localparam int READINGS_MAX  = 5;
  localparam int SETTLE_CYCLES = 300;
  localparam int HOLD_CYCLES   = 600;
  localparam int TARGET_ITEMS  = 1050;

  typedef struct {
    temp_t temp;
    temp_t avg;
  } reading_t;

  // Tracks the averager's sums, history ring and registers, and holds the readings
  // still owed by the block.
  class conversion_scoreboard;
    logic [2:0]        num_readings;
    logic [15:0]       ref_mv;
    logic [3:0]        avg_depth;
    logic [15:0]       zero_offset;
    logic [15:0]       slope_div;
    longint unsigned   sample_sum;
    int unsigned       taken;
    int                history[RING_DEPTH];
    int unsigned       slot;
    reading_t          owed_q[$];
    int                fails;

    function new();
      num_readings = RST_NUM_READINGS;
      ref_mv       = RST_REF_VOLTAGE;
      avg_depth    = RST_AVG_DEPTH;
      zero_offset  = RST_ZERO_OFFSET;
      slope_div    = RST_SLOPE_DIVISOR;
      sample_sum   = 0;
      taken        = 0;
      slot         = 0;
      fails        = 0;
      foreach (history[i]) history[i] = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, cfg_data_t value);
      case (idx)
        REG_NUM_READINGS:  num_readings = value[2:0];
        REG_REF_VOLTAGE:   ref_mv = value;
        REG_AVG_DEPTH:     avg_depth = value[3:0];
        REG_ZERO_OFFSET:   zero_offset = value;
        REG_SLOPE_DIVISOR: slope_div = value;
        default: ;
      endcase
    endfunction

    function void note_sample(sample_t raw);
      int unsigned     n;
      int unsigned     depth;
      int unsigned     divisor;
      int unsigned     idx;
      longint unsigned mv;
      longint          t;
      int              acc;
      reading_t        r;
      n = (num_readings == 0) ? 1 :
          (num_readings > READINGS_MAX) ? READINGS_MAX : num_readings;
      sample_sum += raw;
      taken++;
      // a lowered count completes on the first reading at or past it
      if (taken < n) return;
      mv = sample_sum * ref_mv / 65535 / n;
      sample_sum = 0;
      taken = 0;
      divisor = (slope_div == 0) ? 1 : slope_div;
      t = (longint'(mv) - longint'(zero_offset)) / longint'(divisor);
      if (t > TEMP_CEIL) t = TEMP_CEIL;
      if (t < -TEMP_FLOOR_MAG) t = -TEMP_FLOOR_MAG;
      if (slot >= RING_DEPTH) slot = 0;
      history[slot] = int'(t);
      slot++;
      if (slot >= RING_DEPTH) slot = 0;
      depth = (avg_depth == 0) ? 1 :
              (avg_depth > RING_DEPTH) ? RING_DEPTH : avg_depth;
      idx = (slot == 0) ? RING_DEPTH - 1 : slot - 1;
      acc = 0;
      for (int i = 0; i < depth; i++) begin
        acc += history[idx];
        idx = (idx == 0) ? RING_DEPTH - 1 : idx - 1;
      end
      r.temp = t[15:0];
      r.avg  = temp_t'(acc / int'(depth));
      owed_q.push_back(r);
    endfunction

    function void report(string what, temp_t want, logic [15:0] got);
      fails++;
      if (fails <= 10)
        $display("%0t: %s expected %0d, got %0d", $time, what, want, $signed(got));
    endfunction

    function void check_result(logic [31:0] beat);
      reading_t want;
      if (owed_q.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("%0t: unexpected result beat %h", $time, beat);
        return;
      end
      want = owed_q.pop_front();
      if (beat[15:0] !== want.temp) report("temperature", want.temp, beat[15:0]);
      if (beat[31:16] !== want.avg) report("average", want.avg, beat[31:16]);
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  sample_t     s_tdata;   // [15:0] raw_sample
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // [15:0] temperature, [31:16] average
  logic        cfg_we;
  cfg_idx_t    cfg_index;
  cfg_data_t   cfg_data;

  bit tx_idle;
  bit rx_idle;
  bit hold_req;
  int items_sent;

  conversion_scoreboard sb = new();

  oversampled_temperature_averager #(
    .HISTORY_DEPTH(RING_DEPTH),
    .MAX_READINGS (READINGS_MAX)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(4_000_000);
    $display("oversampled_temperature_averager: mismatch");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_sample(s_tdata);
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int w;
    m_tready = 1'b0;
    forever begin
      if (hold_req) begin
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      w = rx_idle ? $urandom_range(0, 11) : 0;
      if (w > 0) begin
        m_tready = 1'b0;
        repeat (w) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  // called at a falling edge, returns at a falling edge with tvalid still high
  task automatic send_sample(input sample_t raw);
    int gap;
    gap = tx_idle ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = raw;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    items_sent++;
  endtask

  // drain: every owed reading back, then allow for a partial sum still settling
  task automatic wait_idle();
    s_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_reg(input cfg_idx_t idx, input int unsigned value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value[15:0];
    sb.write_reg(idx, value[15:0]);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic int unsigned pick_reg(int unsigned lo, int unsigned hi,
                                           int unsigned top);
    int unsigned v;
    case ($urandom_range(0, 7))
      0: v = 0;
      1: v = top;
      2: v = lo;
      3: v = hi;
      default: v = $urandom_range(lo, hi);
    endcase
    return v;
  endfunction

  function automatic sample_t random_sample();
    sample_t v;
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = '1;
      default: v = sample_t'($urandom_range(0, 65535));
    endcase
    return v;
  endfunction

  task automatic randomize_config();
    set_reg(REG_NUM_READINGS, pick_reg(1, READINGS_MAX, 7));
    set_reg(REG_AVG_DEPTH, pick_reg(1, RING_DEPTH, 15));
    if ($urandom_range(0, 1)) begin
      // plausible sensor scaling keeps temperatures off the clamps
      set_reg(REG_REF_VOLTAGE, $urandom_range(1000, 5000));
      set_reg(REG_ZERO_OFFSET, $urandom_range(0, 1000));
      set_reg(REG_SLOPE_DIVISOR, $urandom_range(1, 40));
    end else begin
      set_reg(REG_REF_VOLTAGE, pick_reg(0, 65535, 65535));
      set_reg(REG_ZERO_OFFSET, pick_reg(0, 65535, 65535));
      set_reg(REG_SLOPE_DIVISOR, pick_reg(1, 65535, 65535));
    end
  endtask

  task automatic run_directed();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    // reset scaling, sample extremes and alternating bits
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h0001);
    send_sample(16'h8000);
    send_sample(16'h5555);
    send_sample(16'hAAAA);
    // ceiling clamp; divisor zero; depth past ring size
    wait_idle();
    set_reg(REG_REF_VOLTAGE, 65535);
    set_reg(REG_ZERO_OFFSET, 0);
    set_reg(REG_SLOPE_DIVISOR, 0);
    set_reg(REG_AVG_DEPTH, 15);
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    // floor saturation; depth zero
    wait_idle();
    set_reg(REG_ZERO_OFFSET, 65535);
    set_reg(REG_REF_VOLTAGE, 0);
    set_reg(REG_AVG_DEPTH, 0);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    // count above maximum, full ring average
    wait_idle();
    set_reg(REG_NUM_READINGS, 7);
    set_reg(REG_REF_VOLTAGE, 3300);
    set_reg(REG_ZERO_OFFSET, 500);
    set_reg(REG_SLOPE_DIVISOR, 10);
    set_reg(REG_AVG_DEPTH, 10);
    repeat (4) send_sample(16'hFFFF);
    send_sample(random_sample());
    // count zero
    wait_idle();
    set_reg(REG_NUM_READINGS, 0);
    send_sample(16'h7FFF);
    // count lowered mid-conversion: four readings summed, divided by two
    wait_idle();
    set_reg(REG_NUM_READINGS, 5);
    repeat (3) send_sample(random_sample());
    wait_idle();
    set_reg(REG_NUM_READINGS, 2);
    send_sample(random_sample());
  endtask

  task automatic run_random();
    int phase;
    int count;
    phase = 0;
    while (items_sent < TARGET_ITEMS) begin
      wait_idle();
      randomize_config();
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      count = $urandom_range(20, 70);
      if (phase == 3) begin
        // back-to-back samples against a stalled output fill the queue
        set_reg(REG_NUM_READINGS, 1);
        tx_idle  = 1'b0;
        hold_req = 1'b1;
        count    = 30;
      end
      repeat (count) send_sample(random_sample());
      phase++;
    end
  endtask

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_NUM_READINGS;
    cfg_data  = '0;
    tx_idle   = 1'b1;
    rx_idle   = 1'b1;
    hold_req  = 1'b0;
    items_sent = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    run_directed();
    run_random();
    s_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
    if (sb.fails == 0) begin
      $display("oversampled_temperature_averager: match");
    end else begin
      $display("oversampled_temperature_averager: mismatch");
    end
    $finish;
  end

endmodule
